// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the register and interrupt logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/dcri_pkg.sv =====
// Types and constants of the DMA channel register file and interrupt logic.
package dcri_pkg;

    localparam int unsigned NUM_CHANNELS = 13;
    localparam int unsigned BANK1_CHANNELS = 7;

    typedef enum logic [2:0] {
        ACT_READ = 3'd0,
        ACT_WR32 = 3'd1,
        ACT_WR16 = 3'd2,
        ACT_DONE = 3'd3,
        ACT_TAG  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        GLB_NONE,
        GLB_PRIO,
        GLB_PRIO2,
        GLB_ICTRL,
        GLB_ICTRL2,
        GLB_GEN,
        GLB_GIEN
    } t_glob;

    localparam logic [3:0] NIB_MEM    = 4'h0;
    localparam logic [3:0] NIB_CNT    = 4'h4;
    localparam logic [3:0] NIB_CNT_HI = 4'h6;
    localparam logic [3:0] NIB_CTRL   = 4'h8;
    localparam logic [3:0] NIB_TAG    = 4'hc;

    localparam logic [31:0] ADDR_PRIO   = 32'h1f80_10f0;
    localparam logic [31:0] ADDR_PRIO2  = 32'h1f80_1570;
    localparam logic [31:0] ADDR_ICTRL  = 32'h1f80_10f4;
    localparam logic [31:0] ADDR_ICTRL2 = 32'h1f80_1574;
    localparam logic [31:0] ADDR_GEN    = 32'h1f80_1578;
    localparam logic [31:0] ADDR_GIEN   = 32'h1f80_157c;

    localparam logic [7:0] BLK1_FIRST = 8'h08;
    localparam logic [7:0] BLK1_LAST  = 8'h0e;
    localparam logic [7:0] BLK2_FIRST = 8'h50;
    localparam logic [7:0] BLK2_LAST  = 8'h55;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [3:0]  channel;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pulse;
        logic        start_valid;
        logic [3:0]  start_channel;
        logic        bad_access;
    } t_out_word;

    typedef struct packed {
        logic       chan_hit;
        logic [3:0] chan_idx;
        logic [3:0] nib;
        t_glob      glob_sel;
    } t_dec;

endpackage

// ===== rtl/dcri_decode.sv =====
// Address decoder: channel index, register nibble and global register select.
module dcri_decode (
    input  logic [31:0]   i_address,
    output dcri_pkg::t_dec o_dec
);
    import dcri_pkg::*;

    logic [7:0] blk;

    always_comb begin
        blk = i_address[11:4];
        o_dec.nib = i_address[3:0];
        o_dec.chan_hit = 1'b0;
        o_dec.chan_idx = '0;
        if (blk >= BLK1_FIRST && blk <= BLK1_LAST) begin
            o_dec.chan_hit = 1'b1;
            o_dec.chan_idx = {1'b0, blk[2:0]};
        end else if (blk >= BLK2_FIRST && blk <= BLK2_LAST) begin
            o_dec.chan_hit = 1'b1;
            o_dec.chan_idx = {1'b0, blk[2:0]} + 4'(BANK1_CHANNELS);
        end
        unique case (i_address)
            ADDR_PRIO:   o_dec.glob_sel = GLB_PRIO;
            ADDR_PRIO2:  o_dec.glob_sel = GLB_PRIO2;
            ADDR_ICTRL:  o_dec.glob_sel = GLB_ICTRL;
            ADDR_ICTRL2: o_dec.glob_sel = GLB_ICTRL2;
            ADDR_GEN:    o_dec.glob_sel = GLB_GEN;
            ADDR_GIEN:   o_dec.glob_sel = GLB_GIEN;
            default:     o_dec.glob_sel = GLB_NONE;
        endcase
    end

endmodule

// ===== rtl/dcri_regfile.sv =====
// Channel and global registers, update logic and interrupt evaluation.
`include "assert_macros.svh"

module dcri_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  dcri_pkg::t_in_word   i_word,
    input  dcri_pkg::t_dec       i_dec,
    output dcri_pkg::t_out_word  o_res
);
    import dcri_pkg::*;

    logic [31:0] r_mem_addr [NUM_CHANNELS];
    logic [31:0] r_blk_cnt  [NUM_CHANNELS];
    logic [31:0] r_control  [NUM_CHANNELS];
    logic [31:0] r_tag_addr [NUM_CHANNELS];
    logic [31:0] r_prio, r_prio2, r_ictrl, r_ictrl2, r_gen, r_gien;
    logic [31:0] n_prio, n_prio2, n_ictrl, n_ictrl2, n_gen, n_gien;

    logic        we_mem, we_cnt, we_ctrl, we_tag;
    logic [31:0] n_cnt;
    logic [31:0] d;
    logic [3:0]  c;
    logic [3:0]  k2;
    logic [6:0]  done1;
    logic [5:0]  done2;
    logic [31:0] icp, ic2p, giep;
    logic        do_eval, mif;
    t_action     act;

    always_comb begin
        act = t_action'(i_word.action);
        d = i_word.write_data;
        c = i_dec.chan_idx;
        k2 = i_word.channel - 4'(BANK1_CHANNELS);
        done1 = (i_word.channel < 4'(BANK1_CHANNELS)) ? 7'(7'd1 << i_word.channel[2:0]) : '0;
        done2 = (i_word.channel >= 4'(BANK1_CHANNELS) && i_word.channel < 4'(NUM_CHANNELS))
              ? 6'(6'd1 << k2[2:0]) : '0;

        o_res = '0;
        we_mem = 1'b0;
        we_cnt = 1'b0;
        we_ctrl = 1'b0;
        we_tag = 1'b0;
        n_cnt = d;
        n_prio = r_prio;
        n_prio2 = r_prio2;
        n_gen = r_gen;
        icp = r_ictrl;
        ic2p = r_ictrl2;
        giep = r_gien;
        do_eval = 1'b0;

        unique case (act)
            ACT_READ: begin
                if (i_dec.chan_hit) begin
                    unique case (i_dec.nib)
                        NIB_MEM:  o_res.read_data = r_mem_addr[c];
                        NIB_CNT:  o_res.read_data = r_blk_cnt[c];
                        NIB_CTRL: o_res.read_data = r_control[c];
                        NIB_TAG:  o_res.read_data = r_tag_addr[c];
                        default:  o_res.bad_access = 1'b1;
                    endcase
                end else begin
                    unique case (i_dec.glob_sel)
                        GLB_PRIO:   o_res.read_data = r_prio;
                        GLB_PRIO2:  o_res.read_data = r_prio2;
                        GLB_ICTRL:  o_res.read_data = r_ictrl;
                        GLB_ICTRL2: o_res.read_data = r_ictrl2;
                        GLB_GEN:    o_res.read_data = r_gen;
                        GLB_GIEN:   o_res.read_data = r_gien;
                        default:    o_res.bad_access = 1'b1;
                    endcase
                end
            end
            ACT_WR32: begin
                if (i_dec.chan_hit) begin
                    unique case (i_dec.nib)
                        NIB_MEM: we_mem = 1'b1;
                        NIB_CNT: we_cnt = 1'b1;
                        NIB_CTRL: begin
                            we_ctrl = 1'b1;
                            o_res.start_valid = d[24];
                            o_res.start_channel = d[24] ? c : '0;
                        end
                        NIB_TAG: we_tag = 1'b1;
                        default: o_res.bad_access = 1'b1;
                    endcase
                end else begin
                    unique case (i_dec.glob_sel)
                        GLB_PRIO:  n_prio = d;
                        GLB_PRIO2: n_prio2 = d;
                        GLB_ICTRL: begin
                            icp = {r_ictrl[31], r_ictrl[30:24] & ~d[30:24], d[23:0]};
                            do_eval = 1'b1;
                        end
                        GLB_ICTRL2: begin
                            ic2p = {r_ictrl2[31:30], r_ictrl2[29:24] & ~d[29:24], d[23:0]};
                            do_eval = 1'b1;
                        end
                        GLB_GEN: n_gen = d;
                        GLB_GIEN: begin
                            giep = d;
                            do_eval = 1'b1;
                        end
                        default: o_res.bad_access = 1'b1;
                    endcase
                end
            end
            ACT_WR16: begin
                if (i_dec.chan_hit && i_dec.nib == NIB_CNT) begin
                    we_cnt = 1'b1;
                    n_cnt = {r_blk_cnt[c][31:16], d[15:0]};
                end else if (i_dec.chan_hit && i_dec.nib == NIB_CNT_HI) begin
                    we_cnt = 1'b1;
                    n_cnt = {d[15:0], r_blk_cnt[c][15:0]};
                end else begin
                    o_res.bad_access = 1'b1;
                end
            end
            ACT_DONE: begin
                if (i_word.channel < 4'(NUM_CHANNELS)) begin
                    icp[30:24] = r_ictrl[30:24] | (done1 & r_ictrl[22:16]);
                    ic2p[29:24] = r_ictrl2[29:24] | (done2 & r_ictrl2[21:16]);
                    do_eval = 1'b1;
                end
            end
            ACT_TAG: o_res.irq_pulse = r_ictrl2[10];
            default: ;
        endcase

        mif = (icp[15] | (icp[23] & ((|icp[30:24]) | (|ic2p[29:24])))) & giep[0];
        n_ictrl = icp;
        n_ictrl2 = ic2p;
        n_gien = giep;
        if (do_eval) begin
            n_ictrl[31] = mif;
            o_res.irq_pulse = mif & ~giep[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_mem_addr[i] <= '0;
                r_blk_cnt[i] <= '0;
                r_control[i] <= '0;
                r_tag_addr[i] <= '0;
            end
            r_prio <= '0;
            r_prio2 <= '0;
            r_ictrl <= '0;
            r_ictrl2 <= '0;
            r_gen <= '0;
            r_gien <= 32'd1;
        end else if (i_fire) begin
            if (we_mem) r_mem_addr[c] <= d;
            if (we_cnt) r_blk_cnt[c] <= n_cnt;
            if (we_ctrl) r_control[c] <= d;
            if (we_tag) r_tag_addr[c] <= d;
            r_prio <= n_prio;
            r_prio2 <= n_prio2;
            r_ictrl <= n_ictrl;
            r_ictrl2 <= n_ictrl2;
            r_gen <= n_gen;
            r_gien <= n_gien;
        end
    end

    `ASSERT_IMPL(a_start_ctrl, i_clk, i_rst_n, o_res.start_valid,
        act == ACT_WR32 && i_dec.chan_hit && i_dec.nib == NIB_CTRL)
    `ASSERT_NEXT(a_pulse_sets_mif, i_clk, i_rst_n,
        i_fire && o_res.irq_pulse && act != ACT_TAG, r_ictrl[31])
    `ASSERT_IMPL(a_bad_quiet, i_clk, i_rst_n, o_res.bad_access,
        o_res.read_data == '0 && !o_res.irq_pulse && !o_res.start_valid)

endmodule

// ===== rtl/dma_channel_regs_and_irq_unit.sv =====
// Top level of the DMA channel register file and interrupt logic.
//
// One input channel carries bus reads, 32-bit writes, 16-bit block-count
// writes, channel-done events and tag-interrupt events; every word accepted
// yields exactly one result word on the output channel.
// A word is accepted on an edge where its valid is high and its stall is low.
// Each accepted word is held in an input register, decoded and applied to the
// registers, and its result is captured in an output register. The result is
// valid from that output register; one word per cycle is sustained while the
// receiver does not stall, set by the single decode and update step.
// A following word sees every register change made by the word before it.
// When the receiver stalls, the result holds and the input register keeps one
// more word; the input stalls only when both are occupied.
// Reset clears both stages, zeroes all registers and sets the interrupt
// enable word to one.
module dma_channel_regs_and_irq_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dcri_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dcri_pkg::t_out_word  o_out_data
);
    import dcri_pkg::*;

    logic      r_in_valid, r_out_valid;
    t_in_word  r_in_data;
    t_out_word r_out_data;
    t_out_word res;
    t_dec      dec;
    logic      out_free, fire;

    assign out_free = !r_out_valid || !i_out_stall;
    assign fire = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    dcri_decode u_decode (
        .i_address (r_in_data.address),
        .o_dec     (dec)
    );

    dcri_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in_data),
        .i_dec   (dec),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (out_free) r_out_valid <= r_in_valid;
        end
        if (i_in_valid && !o_in_stall) r_in_data <= i_in_data;
        if (fire) r_out_data <= res;
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the DMA channel register file and interrupt unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcri_pkg::*;

    localparam logic [2:0]  ACT_UNDEF_FIRST = 3'd5;
    localparam logic [2:0]  ACT_UNDEF_LAST  = 3'd7;
    localparam logic [31:0] LOW24_MASK      = 32'h00ff_ffff;
    localparam logic [31:0] FLAG1_MASK      = 32'h7f00_0000;
    localparam logic [31:0] FLAG2_MASK      = 32'h3f00_0000;
    localparam int          BIT_BUS_ERR     = 15;
    localparam int          BIT_MASTER_EN   = 23;
    localparam int          BIT_MASTER_FLAG = 31;
    localparam int          BIT_START       = 24;
    localparam int          BIT_TAG_IRQ     = 10;
    localparam int          ENABLE_BASE     = 16;
    localparam int          FLAG_BASE       = 24;
    localparam int          GIEN_ON         = 0;
    localparam int          GIEN_HOLD       = 1;
    localparam int          HOLD_CYCLES     = 64;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    dma_channel_regs_and_irq_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    logic [31:0] m_addr [NUM_CHANNELS];
    logic [31:0] m_count [NUM_CHANNELS];
    logic [31:0] m_ctrl [NUM_CHANNELS];
    logic [31:0] m_tag [NUM_CHANNELS];
    logic [31:0] m_prio, m_prio2, m_ictrl, m_ictrl2, m_gen, m_gien;

    t_out_word pending_results[$];
    t_out_word want;
    int errors = 0;
    int n_checked = 0, n_words = 0, n_reads = 0, n_wr32 = 0, n_wr16 = 0;
    int n_done = 0, n_tag = 0, n_pulses = 0, n_starts = 0, n_bad = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    bit hold_req = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("dma_channel_regs_and_irq_unit test failed");
        $finish;
    end

    function automatic int random_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 24);
    endfunction

    function automatic logic raise_irq();
        logic flags;
        logic mif;
        flags = |(m_ictrl & FLAG1_MASK) || |(m_ictrl2 & FLAG2_MASK);
        mif = (m_ictrl[BIT_BUS_ERR] || (m_ictrl[BIT_MASTER_EN] && flags)) && m_gien[GIEN_ON];
        m_ictrl[BIT_MASTER_FLAG] = mif;
        return mif && !m_gien[GIEN_HOLD];
    endfunction

    function automatic t_out_word apply_bus_word(input t_in_word w);
        t_out_word r;
        logic [7:0] blk;
        logic [31:0] d;
        int ch;
        int k;
        r = '0;
        d = w.write_data;
        blk = w.address[11:4];
        ch = -1;
        if (blk >= BLK1_FIRST && blk <= BLK1_LAST) begin
            ch = int'(blk - BLK1_FIRST);
        end else if (blk >= BLK2_FIRST && blk <= BLK2_LAST) begin
            ch = int'(blk - BLK2_FIRST) + BANK1_CHANNELS;
        end
        n_words++;
        case (w.action)
            ACT_READ: begin
                n_reads++;
                if (ch >= 0) begin
                    case (w.address[3:0])
                        NIB_MEM:  r.read_data = m_addr[ch];
                        NIB_CNT:  r.read_data = m_count[ch];
                        NIB_CTRL: r.read_data = m_ctrl[ch];
                        NIB_TAG:  r.read_data = m_tag[ch];
                        default:  r.bad_access = 1'b1;
                    endcase
                end else begin
                    case (w.address)
                        ADDR_PRIO:   r.read_data = m_prio;
                        ADDR_PRIO2:  r.read_data = m_prio2;
                        ADDR_ICTRL:  r.read_data = m_ictrl;
                        ADDR_ICTRL2: r.read_data = m_ictrl2;
                        ADDR_GEN:    r.read_data = m_gen;
                        ADDR_GIEN:   r.read_data = m_gien;
                        default:     r.bad_access = 1'b1;
                    endcase
                end
            end
            ACT_WR32: begin
                n_wr32++;
                if (ch >= 0) begin
                    case (w.address[3:0])
                        NIB_MEM: m_addr[ch] = d;
                        NIB_CNT: m_count[ch] = d;
                        NIB_CTRL: begin
                            m_ctrl[ch] = d;
                            if (d[BIT_START]) begin
                                r.start_valid = 1'b1;
                                r.start_channel = 4'(ch);
                            end
                        end
                        NIB_TAG: m_tag[ch] = d;
                        default: r.bad_access = 1'b1;
                    endcase
                end else begin
                    case (w.address)
                        ADDR_PRIO:  m_prio = d;
                        ADDR_PRIO2: m_prio2 = d;
                        ADDR_ICTRL: begin
                            m_ictrl = (m_ictrl & ~LOW24_MASK) | (d & LOW24_MASK);
                            m_ictrl &= ~(d & FLAG1_MASK);
                            r.irq_pulse = raise_irq();
                        end
                        ADDR_ICTRL2: begin
                            m_ictrl2 = (m_ictrl2 & ~LOW24_MASK) | (d & LOW24_MASK);
                            m_ictrl2 &= ~(d & FLAG2_MASK);
                            r.irq_pulse = raise_irq();
                        end
                        ADDR_GEN: m_gen = d;
                        ADDR_GIEN: begin
                            m_gien = d;
                            r.irq_pulse = raise_irq();
                        end
                        default: r.bad_access = 1'b1;
                    endcase
                end
            end
            ACT_WR16: begin
                n_wr16++;
                if (ch >= 0 && w.address[3:0] == NIB_CNT) begin
                    m_count[ch][15:0] = d[15:0];
                end else if (ch >= 0 && w.address[3:0] == NIB_CNT_HI) begin
                    m_count[ch][31:16] = d[15:0];
                end else begin
                    r.bad_access = 1'b1;
                end
            end
            ACT_DONE: begin
                n_done++;
                if (w.channel < NUM_CHANNELS) begin
                    if (w.channel < BANK1_CHANNELS) begin
                        k = int'(w.channel);
                        if (m_ictrl[ENABLE_BASE + k]) m_ictrl[FLAG_BASE + k] = 1'b1;
                    end else begin
                        k = int'(w.channel) - BANK1_CHANNELS;
                        if (m_ictrl2[ENABLE_BASE + k]) m_ictrl2[FLAG_BASE + k] = 1'b1;
                    end
                    r.irq_pulse = raise_irq();
                end
            end
            ACT_TAG: begin
                n_tag++;
                r.irq_pulse = m_ictrl2[BIT_TAG_IRQ];
            end
            default: ;
        endcase
        n_pulses += r.irq_pulse;
        n_starts += r.start_valid;
        n_bad += r.bad_access;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got);
        if (exp_v !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    report("read_data", want.read_data, o_out_data.read_data);
                    report("irq_pulse", 32'(want.irq_pulse), 32'(o_out_data.irq_pulse));
                    report("start_valid", 32'(want.start_valid),
                           32'(o_out_data.start_valid));
                    report("start_channel", 32'(want.start_channel),
                           32'(o_out_data.start_channel));
                    report("bad_access", 32'(want.bad_access), 32'(o_out_data.bad_access));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(apply_bus_word(i_in_data));
            end
        end
    end

    initial begin
        int left;
        left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (left > 0) begin
                i_out_stall = 1'b1;
                left--;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                left = random_len() - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_word(input logic [2:0] act, input logic [31:0] addr,
                             input logic [31:0] data, input logic [3:0] ch);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data.action = act;
        i_in_data.address = addr;
        i_in_data.write_data = data;
        i_in_data.channel = ch;
        do @(posedge i_clk); while (o_in_stall);
        gap = ($urandom_range(0, 99) < in_idle_pct) ? random_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_in_data = t_in_word'({$urandom, $urandom, 7'($urandom)});
        end
    endtask

    function automatic logic [31:0] chan_reg_addr(input int ch, input logic [3:0] nib);
        logic [31:0] a;
        a = $urandom;
        a[11:4] = (ch < BANK1_CHANNELS) ? BLK1_FIRST + 8'(ch)
                                        : BLK2_FIRST + 8'(ch - BANK1_CHANNELS);
        a[3:0] = nib;
        return a;
    endfunction

    function automatic logic [31:0] pick_reg_addr(input bit half);
        int r;
        logic [3:0] nib;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            if ($urandom_range(0, 9) == 0) begin
                nib = 4'($urandom);
            end else if (half) begin
                nib = $urandom_range(0, 1) ? NIB_CNT : NIB_CNT_HI;
            end else begin
                case ($urandom_range(0, 3))
                    0: nib = NIB_MEM;
                    1: nib = NIB_CNT;
                    2: nib = NIB_CTRL;
                    default: nib = NIB_TAG;
                endcase
            end
            return chan_reg_addr($urandom_range(0, NUM_CHANNELS - 1), nib);
        end else if (r < 95) begin
            case ($urandom_range(0, 5))
                0: return ADDR_PRIO;
                1: return ADDR_PRIO2;
                2: return ADDR_ICTRL;
                3: return ADDR_ICTRL2;
                4: return ADDR_GEN;
                default: return ADDR_GIEN;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_directed_cases();
        in_idle_pct = 20;
        out_stall_pct = 20;
        send_word(ACT_READ, ADDR_GIEN, '0, '0);
        send_word(ACT_READ, chan_reg_addr(0, NIB_MEM), '1, 4'hf);
        send_word(ACT_WR32, ADDR_ICTRL, '1, '0);
        send_word(ACT_DONE, '0, '0, 4'd0);
        send_word(ACT_DONE, '1, '1, 4'd12);
        send_word(ACT_WR32, ADDR_ICTRL2, 32'h00ff_ffff, '0);
        send_word(ACT_DONE, '0, '0, 4'd12);
        send_word(ACT_TAG, '0, '0, '0);
        send_word(ACT_DONE, '0, '0, 4'd15);
        send_word(ACT_WR32, ADDR_GIEN, 32'h3, '0);
        send_word(ACT_WR32, ADDR_GIEN, 32'h0, '0);
        send_word(ACT_WR32, chan_reg_addr(6, NIB_CTRL), 32'h0100_0000, '0);
        send_word(ACT_WR32, chan_reg_addr(12, NIB_CTRL), '1, '0);
        send_word(ACT_WR16, chan_reg_addr(7, NIB_CNT), 32'hffff_1234, '0);
        send_word(ACT_WR16, chan_reg_addr(7, NIB_CNT_HI), 32'h0000_abcd, '0);
        send_word(ACT_READ, chan_reg_addr(7, NIB_CNT), '0, '0);
        send_word(ACT_WR16, chan_reg_addr(7, NIB_CTRL), '1, '0);
        send_word(ACT_WR16, ADDR_ICTRL, '1, '0);
        send_word(ACT_READ, 32'h1f80_10f8, '0, '0);
        send_word(ACT_WR32, '1, '1, '1);
        send_word(ACT_READ, chan_reg_addr(0, 4'h2), '0, '0);
        send_word(ACT_UNDEF_LAST, '1, '1, '1);
        send_word(ACT_READ, ADDR_ICTRL, '0, '0);
        send_word(ACT_WR32, ADDR_ICTRL, 32'h7f00_0000, '0);
        send_word(ACT_WR32, ADDR_GIEN, 32'h1, '0);
    endtask

    task automatic send_random_word();
        int r;
        logic [31:0] a;
        logic [31:0] d;
        r = $urandom_range(0, 99);
        d = $urandom;
        if (r < 25) begin
            send_word(ACT_READ, pick_reg_addr(1'b0), d, 4'($urandom));
        end else if (r < 50) begin
            a = pick_reg_addr(1'b0);
            if (a == ADDR_ICTRL || a == ADDR_ICTRL2) begin
                if ($urandom_range(0, 1)) d[31:24] = '0;
            end else if (a == ADDR_GIEN && $urandom_range(0, 3) != 0) begin
                d = $urandom_range(0, 3);
            end
            send_word(ACT_WR32, a, d, 4'($urandom));
        end else if (r < 62) begin
            send_word(ACT_WR16, pick_reg_addr(1'b1), d, 4'($urandom));
        end else if (r < 85) begin
            send_word(ACT_DONE, $urandom, d, 4'($urandom));
        end else if (r < 92) begin
            send_word(ACT_TAG, $urandom, d, 4'($urandom));
        end else if (r < 96) begin
            send_word(3'($urandom), $urandom, d, 4'($urandom));
        end else begin
            send_word(3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST)), $urandom, d,
                      4'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                case ((i / 100) % 4)
                    0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                    1: begin in_idle_pct = 20; out_stall_pct = 20; end
                    2: begin in_idle_pct = 60; out_stall_pct = 10; end
                    default: begin in_idle_pct = 10; out_stall_pct = 60; end
                endcase
            end
            send_random_word();
        end
    endtask

    task automatic test_output_holdoff();
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_req = 1;
        repeat (40) send_random_word();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            m_addr[c] = '0;
            m_count[c] = '0;
            m_ctrl[c] = '0;
            m_tag[c] = '0;
        end
        m_prio = '0;
        m_prio2 = '0;
        m_ictrl = '0;
        m_ictrl2 = '0;
        m_gen = '0;
        m_gien = 32'd1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(500);
        test_output_holdoff();
        test_random_traffic(540);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Checked %0d results of %0d words: %0d reads, %0d 32-bit and %0d 16-bit writes,",
                 n_checked, n_words, n_reads, n_wr32, n_wr16);
        $display("%0d done and %0d tag events, %0d interrupts, %0d starts, %0d bad accesses.",
                 n_done, n_tag, n_pulses, n_starts, n_bad);
        if (errors == 0) begin
            $display("dma_channel_regs_and_irq_unit test passed");
        end else begin
            $display("dma_channel_regs_and_irq_unit test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dcri_pkg.sv
rtl/dcri_decode.sv
rtl/dcri_regfile.sv
rtl/dma_channel_regs_and_irq_unit.sv
bench/testbench.sv
